FILE: design/xeu_pkg.sv
// Shared constants, types and entity tables of the XML entity unescaper.
`default_nettype none

package xeu_pkg;

	// Depth of the buffer that holds the text of an open entity.
	localparam int HOLD_DEPTH = 16;
	localparam int IDX_W      = $clog2(HOLD_DEPTH);
	localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);

	// Command queue between the front and back ends.
	localparam int FIFO_DEPTH = 4;
	localparam int FPTR_W     = $clog2(FIFO_DEPTH);
	localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

	// Characters with a meaning of their own.
	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_SEMI = 8'h3b;
	localparam logic [7:0] CH_X    = 8'h78;

	// Named entities: lt, gt, amp, apos, quot.
	localparam int NUM_ENT = 5;

	typedef enum logic [1:0] {
		TAIL_NONE = 2'd0,
		TAIL_BYTE = 2'd1,
		TAIL_NUM  = 2'd2
	} tail_kind_t;

	// One command: an optional flush of '&' plus held text, then an optional tail.
	typedef struct packed {
		logic             do_flush;
		logic [CNT_W-1:0] flush_cnt;
		tail_kind_t       tail;
		logic [31:0]      tail_val;
		logic             fin;
	} cmd_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [7:0]       data;
	} hold_wr_t;

	typedef struct packed {
		logic flush_done;
	} back_stat_t;

	// Length of a named entity including the closing ';'.
	function automatic logic [2:0] ent_len(input logic [2:0] k);
		logic [2:0] len;
		case (k)
			3'd0:    len = 3'd3;
			3'd1:    len = 3'd3;
			3'd2:    len = 3'd4;
			3'd3:    len = 3'd5;
			3'd4:    len = 3'd5;
			default: len = 3'd0;
		endcase
		return len;
	endfunction

	// Character at a position of a named entity's text.
	function automatic logic [7:0] ent_char(input logic [2:0] k, input logic [2:0] pos);
		logic [7:0] ch;
		ch = 8'h00;
		case (k)
			3'd0: begin
				case (pos)
					3'd0:    ch = 8'h6c; // l
					3'd1:    ch = 8'h74; // t
					3'd2:    ch = CH_SEMI;
					default: ch = 8'h00;
				endcase
			end
			3'd1: begin
				case (pos)
					3'd0:    ch = 8'h67; // g
					3'd1:    ch = 8'h74; // t
					3'd2:    ch = CH_SEMI;
					default: ch = 8'h00;
				endcase
			end
			3'd2: begin
				case (pos)
					3'd0:    ch = 8'h61; // a
					3'd1:    ch = 8'h6d; // m
					3'd2:    ch = 8'h70; // p
					3'd3:    ch = CH_SEMI;
					default: ch = 8'h00;
				endcase
			end
			3'd3: begin
				case (pos)
					3'd0:    ch = 8'h61; // a
					3'd1:    ch = 8'h70; // p
					3'd2:    ch = 8'h6f; // o
					3'd3:    ch = 8'h73; // s
					3'd4:    ch = CH_SEMI;
					default: ch = 8'h00;
				endcase
			end
			3'd4: begin
				case (pos)
					3'd0:    ch = 8'h71; // q
					3'd1:    ch = 8'h75; // u
					3'd2:    ch = 8'h6f; // o
					3'd3:    ch = 8'h74; // t
					3'd4:    ch = CH_SEMI;
					default: ch = 8'h00;
				endcase
			end
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// Replacement character of a named entity.
	function automatic logic [7:0] ent_repl(input logic [2:0] k);
		logic [7:0] ch;
		case (k)
			3'd0:    ch = 8'h3c;
			3'd1:    ch = 8'h3e;
			3'd2:    ch = 8'h26;
			3'd3:    ch = 8'h27;
			3'd4:    ch = 8'h22;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// Digit value: bit 4 is set for a hex digit of either case, bits 3:0 hold its value.
	function automatic logic [4:0] digit_val(input logic [7:0] c);
		logic [7:0] t;
		logic [4:0] r;
		r = 5'd0;
		t = 8'h00;
		if (c >= 8'h30 && c <= 8'h39) begin
			t = c - 8'h30;
			r = {1'b1, t[3:0]};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			t = c - 8'h57;
			r = {1'b1, t[3:0]};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			t = c - 8'h37;
			r = {1'b1, t[3:0]};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: design/xeu_if.sv
// Valid/ready channel interfaces for text bytes in and decoded bytes out.
`default_nettype none

interface xeu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_final;

	modport source (output valid, output in_byte, output in_final, input ready);
	modport sink   (input valid, input in_byte, input in_final, output ready);
endinterface

interface xeu_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_end;
	logic       text_end;

	modport source (output valid, output out_byte, output run_end, output text_end, input ready);
	modport sink   (input valid, input out_byte, input run_end, input text_end, output ready);
endinterface

`default_nettype wire

FILE: design/xml_entity_unescaper.sv
// Top level of the XML entity unescaper: front end, command queue and back end.
//
//   Channel    Direction  Payload                          Handshake
//   text_in    in         in_byte[7:0], in_final           valid/ready, taken when both high
//   text_out   out        out_byte[7:0], run_end, text_end valid/ready, taken when both high
//
// Plain bytes and completed entities run at one item per cycle while the queue is not full,
// no flush is pending and the output is not stalled; an item that yields more than one byte
// issues them in turn from the single output register of the back end. A failed entity, or
// the end of the text with an entity still open, queues a flush of '&' plus the held text; no
// further item is taken until the back end has issued the last byte of that flush, since the
// hold buffer is then reused. With the queue empty and the output register free, an item's
// first byte is registered in the queue and then in the output register before it is offered.
// Reset clears the control state only; the hold buffer is never cleared and is read only where
// written. Either side may stall freely: the four-entry command queue decouples the two ends.
`default_nettype none

module xml_entity_unescaper (
	input  logic      clk,
	input  logic      arst_n,
	xeu_in_if.sink    text_in,
	xeu_out_if.source text_out
);
	import xeu_pkg::*;

	// Commands from the front end, one per item that yields any output.
	cmd_t       push_cmd, head_cmd;
	logic       push, q_full, head_valid, pop;

	// The front end writes the text of an open entity into the back end's hold buffer.
	hold_wr_t   hold_wr;

	// The back end tells the front end when a flush has been read out.
	back_stat_t stat;

	xeu_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.text_in (text_in),
		.q_full  (q_full),
		.stat    (stat),
		.q_push  (push),
		.q_cmd   (push_cmd),
		.hold_wr (hold_wr)
	);

	xeu_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.din        (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head_cmd)
	);

	xeu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head_cmd),
		.pop        (pop),
		.hold_wr    (hold_wr),
		.stat       (stat),
		.text_out   (text_out)
	);

endmodule

`default_nettype wire

FILE: design/xeu_front.sv
// Front end: accepts text bytes, tracks the open entity and issues output commands.
`default_nettype none

module xeu_front (
	input  logic                clk,
	input  logic                arst_n,
	xeu_in_if.sink              text_in,
	input  logic                q_full,
	input  xeu_pkg::back_stat_t stat,
	output logic                q_push,
	output xeu_pkg::cmd_t       q_cmd,
	output xeu_pkg::hold_wr_t   hold_wr
);
	import xeu_pkg::*;

	typedef enum logic [4:0] {
		M_IDLE   = 5'b00001,
		M_AMP    = 5'b00010,
		M_NAME   = 5'b00100,
		M_NSTART = 5'b01000,
		M_NDIG   = 5'b10000
	} mode_t;

	mode_t              mode_q, mode_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic [31:0]        acc_q, acc_d;
	logic               hex_q, hex_d;
	logic [NUM_ENT-1:0] mask_q, mask_d;
	logic               pending_q;

	logic               accept;
	logic [7:0]         c;
	logic               fin;
	logic [NUM_ENT-1:0] match, done;
	logic [7:0]         repl;
	logic [4:0]         dv;
	logic [31:0]        acc_next;
	logic               can_hold, do_hold, fail, clear, idle;
	logic               do_flush;
	logic [CNT_W-1:0]   fcnt;
	tail_kind_t         tail;
	logic [31:0]        tval;

	assign text_in.ready = !q_full && !pending_q;
	assign accept        = text_in.valid && text_in.ready;

	always_comb begin
		c   = text_in.in_byte;
		fin = text_in.in_final;

		// Candidate entities still agreeing with the held text.
		for (int k = 0; k < NUM_ENT; k++) begin
			match[k] = mask_q[k] && (cnt_q < CNT_W'(ent_len(3'(k))))
				&& (ent_char(3'(k), cnt_q[2:0]) == c);
			done[k]  = match[k] && ((cnt_q + CNT_W'(1)) == CNT_W'(ent_len(3'(k))));
		end
		repl = 8'h00;
		for (int k = NUM_ENT - 1; k >= 0; k--) begin
			if (done[k]) repl = ent_repl(3'(k));
		end

		dv       = digit_val(c);
		can_hold = cnt_q < CNT_W'(HOLD_DEPTH);
		if (hex_q)
			acc_next = {acc_q[27:0], 4'h0} + 32'(dv[3:0]);
		else
			acc_next = {acc_q[28:0], 3'b000} + {acc_q[30:0], 1'b0} + 32'(dv[3:0]);

		mode_d   = mode_q;
		cnt_d    = cnt_q;
		acc_d    = acc_q;
		hex_d    = hex_q;
		mask_d   = mask_q;
		do_hold  = 1'b0;
		fail     = 1'b0;
		clear    = 1'b0;
		idle     = 1'b0;
		do_flush = 1'b0;
		fcnt     = cnt_q;
		tail     = TAIL_NONE;
		tval     = 32'd0;

		unique case (mode_q) inside
			M_AMP, M_NAME: begin
				if (mode_q == M_AMP && c == CH_HASH) begin
					if (can_hold) begin
						do_hold = 1'b1;
						mode_d  = M_NSTART;
					end else begin
						fail = 1'b1;
					end
				end else if (|done) begin
					tail  = TAIL_BYTE;
					tval  = 32'(repl);
					clear = 1'b1;
				end else if ((|(match & ~done)) && can_hold) begin
					do_hold = 1'b1;
					mode_d  = M_NAME;
					mask_d  = match & ~done;
				end else begin
					fail = 1'b1;
				end
			end
			M_NSTART, M_NDIG: begin
				if (mode_q == M_NSTART && c == CH_X) begin
					if (can_hold) begin
						do_hold = 1'b1;
						hex_d   = 1'b1;
						mode_d  = M_NDIG;
					end else begin
						fail = 1'b1;
					end
				end else if (c == CH_SEMI) begin
					if (acc_q == 32'd0) begin
						fail = 1'b1;
					end else begin
						tail  = TAIL_NUM;
						tval  = acc_q;
						clear = 1'b1;
					end
				end else if (!dv[4] || !can_hold) begin
					fail = 1'b1;
				end else begin
					do_hold = 1'b1;
					acc_d   = acc_next;
					mode_d  = M_NDIG;
				end
			end
			M_IDLE: begin
				idle = 1'b1;
			end
			default: begin
				idle = 1'b1;
			end
		endcase

		// A failed entity is flushed and its breaking byte starts afresh.
		if (fail) begin
			do_flush = 1'b1;
			fcnt     = cnt_q;
			idle     = 1'b1;
		end
		if (do_hold) cnt_d = cnt_q + CNT_W'(1);
		if (clear) begin
			mode_d = M_IDLE;
			cnt_d  = '0;
			acc_d  = 32'd0;
			hex_d  = 1'b0;
		end
		if (idle) begin
			cnt_d = '0;
			acc_d = 32'd0;
			hex_d = 1'b0;
			if (c == CH_AMP) begin
				mode_d = M_AMP;
				mask_d = '1;
			end else begin
				mode_d = M_IDLE;
				tail   = TAIL_BYTE;
				tval   = 32'(c);
			end
		end

		// End of text: whatever entity is still open goes out literally.
		if (fin && mode_d != M_IDLE) begin
			if (do_flush) begin
				tail = TAIL_BYTE;
				tval = 32'(CH_AMP);
			end else begin
				do_flush = 1'b1;
				fcnt     = cnt_d;
			end
			mode_d = M_IDLE;
			cnt_d  = '0;
			acc_d  = 32'd0;
			hex_d  = 1'b0;
		end
	end

	assign q_push          = accept && (do_flush || tail != TAIL_NONE);
	assign q_cmd.do_flush  = do_flush;
	assign q_cmd.flush_cnt = fcnt;
	assign q_cmd.tail      = tail;
	assign q_cmd.tail_val  = tval;
	assign q_cmd.fin       = fin;

	assign hold_wr.en   = accept && do_hold;
	assign hold_wr.addr = cnt_q[IDX_W-1:0];
	assign hold_wr.data = c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= M_IDLE;
			cnt_q     <= '0;
			acc_q     <= 32'd0;
			hex_q     <= 1'b0;
			mask_q    <= '1;
			pending_q <= 1'b0;
		end else begin
			if (accept) begin
				mode_q <= mode_d;
				cnt_q  <= cnt_d;
				acc_q  <= acc_d;
				hex_q  <= hex_d;
				mask_q <= mask_d;
			end
			// The held text must not be overwritten before the back end has read it.
			if (q_push && do_flush)
				pending_q <= 1'b1;
			else if (stat.flush_done)
				pending_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

FILE: design/xeu_fifo.sv
// Short command queue between the front and back ends.
`default_nettype none

module xeu_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  xeu_pkg::cmd_t din,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output xeu_pkg::cmd_t head
);
	import xeu_pkg::*;

	cmd_t              mem_q [FIFO_DEPTH];
	logic [FPTR_W-1:0] wr_q, rd_q;
	logic [FCNT_W-1:0] cnt_q;

	assign full       = cnt_q == FCNT_W'(FIFO_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + FPTR_W'(1);
			if (pop)
				rd_q <= (rd_q == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + FPTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + FCNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - FCNT_W'(1);
		end
	end

endmodule

`default_nettype wire

FILE: design/xeu_back.sv
// Back end: holds the entity text and turns commands into output bytes.
`default_nettype none

module xeu_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  xeu_pkg::cmd_t       head,
	output logic                pop,
	input  xeu_pkg::hold_wr_t   hold_wr,
	output xeu_pkg::back_stat_t stat,
	xeu_out_if.source           text_out
);
	import xeu_pkg::*;

	typedef enum logic [3:0] {
		PH_START = 4'b0001,
		PH_HELD  = 4'b0010,
		PH_TAIL  = 4'b0100,
		PH_NUM   = 4'b1000
	} phase_t;

	logic [7:0]       held_q [HOLD_DEPTH];
	phase_t           phase_q, phase_d, eff;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [23:0]      num_q, num_d;

	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             run_end_q, text_end_q;

	logic             slot_free, go, emit, last, use_held, at_end;
	logic [7:0]       byte_d;

	assign slot_free = !out_valid_q || text_out.ready;
	assign go        = head_valid && slot_free;

	always_comb begin
		eff      = (phase_q == PH_START && !head.do_flush) ? PH_TAIL : phase_q;
		phase_d  = phase_q;
		idx_d    = idx_q;
		num_d    = num_q;
		emit     = 1'b0;
		last     = 1'b0;
		use_held = 1'b0;
		byte_d   = 8'h00;
		at_end   = (CNT_W'(idx_q) + CNT_W'(1)) == head.flush_cnt;

		unique case (eff)
			PH_START: begin
				emit    = 1'b1;
				byte_d  = CH_AMP;
				last    = (head.flush_cnt == '0) && (head.tail == TAIL_NONE);
				phase_d = (head.flush_cnt != '0) ? PH_HELD : PH_TAIL;
				idx_d   = '0;
			end
			PH_HELD: begin
				emit     = 1'b1;
				use_held = 1'b1;
				last     = at_end && (head.tail == TAIL_NONE);
				if (at_end) begin
					phase_d = PH_TAIL;
					idx_d   = '0;
				end else begin
					idx_d = idx_q + IDX_W'(1);
				end
			end
			PH_TAIL: begin
				unique case (head.tail)
					TAIL_BYTE: begin
						emit   = 1'b1;
						byte_d = head.tail_val[7:0];
						last   = 1'b1;
					end
					TAIL_NUM: begin
						emit    = 1'b1;
						byte_d  = head.tail_val[7:0];
						num_d   = head.tail_val[31:8];
						last    = head.tail_val[31:8] == 24'd0;
						phase_d = PH_NUM;
					end
					default: begin
						last = 1'b1;
					end
				endcase
			end
			PH_NUM: begin
				emit   = 1'b1;
				byte_d = num_q[7:0];
				num_d  = {8'h00, num_q[23:8]};
				last   = num_q[23:8] == 16'd0;
			end
			default: begin
				last = 1'b1;
			end
		endcase

		if (last) begin
			phase_d = PH_START;
			idx_d   = '0;
		end
	end

	assign pop             = go && last;
	assign stat.flush_done = pop && head.do_flush;

	assign text_out.valid    = out_valid_q;
	assign text_out.out_byte = out_byte_q;
	assign text_out.run_end  = run_end_q;
	assign text_out.text_end = text_end_q;

	always_ff @(posedge clk) begin
		if (hold_wr.en) held_q[hold_wr.addr] <= hold_wr.data;
		if (go && emit) begin
			out_byte_q <= use_held ? held_q[idx_q] : byte_d;
			run_end_q  <= last;
			text_end_q <= last && head.fin;
		end
		if (go) num_q <= num_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (go) begin
				phase_q <= phase_d;
				idx_q   <= idx_d;
			end
			if (go && emit)
				out_valid_q <= 1'b1;
			else if (text_out.ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

FILE: design/xeu_checker.sv
// Port-level checks of the XML entity unescaper, bound to its top level.
`default_nettype none

module xeu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       in_final,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       run_end,
	input logic       text_end
);

	// Final items taken whose closing byte has not yet been delivered.
	logic [3:0] fin_open_q;
	logic       fin_in, fin_out;

	assign fin_in  = in_valid && in_ready && in_final;
	assign fin_out = out_valid && out_ready && text_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_open_q <= 4'd0;
		end else if (fin_in && !fin_out) begin
			if (fin_open_q != 4'hf) fin_open_q <= fin_open_q + 4'd1;
		end else if (fin_out && !fin_in) begin
			if (fin_open_q != 4'd0) fin_open_q <= fin_open_q - 4'd1;
		end
	end

	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output item withdrawn while stalled");

	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_byte) && $stable(run_end) && $stable(text_end))
		else $error("output item changed while stalled");

	a_text_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && text_end |-> run_end)
		else $error("end of text on an item that does not close its run");

	a_text_end_owed: assert property (@(posedge clk) disable iff (!arst_n)
		fin_out |-> fin_open_q != 4'd0)
		else $error("end of text delivered with no final input item outstanding");

endmodule

bind xml_entity_unescaper xeu_checker u_xeu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (text_in.valid),
	.in_ready  (text_in.ready),
	.in_final  (text_in.in_final),
	.out_valid (text_out.valid),
	.out_ready (text_out.ready),
	.out_byte  (text_out.out_byte),
	.run_end   (text_out.run_end),
	.text_end  (text_out.text_end)
);

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for the XML entity unescaper, with a scoreboard that predicts decoded bytes.
module testbench;
	import xeu_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 10;
	// Random part of the run, counted in input items; the last stretch runs without idling.
	localparam int RANDOM_ITEMS = 400;
	localparam int QUIET_ITEMS  = 60;
	// Cycles allowed after the last expected byte for anything stray to show up.
	localparam int TAIL_CYCLES  = 32;
	localparam int CYCLE_LIMIT  = 400000;

	// Decoder scan states, kept apart from whatever encoding the block uses inside.
	typedef enum logic [2:0] {
		SCAN_IDLE,
		SCAN_AMP,
		SCAN_NAME,
		SCAN_NUM_START,
		SCAN_NUM_DIG
	} scan_mode_t;

	// One decoded byte as it should leave the block.
	typedef struct packed {
		logic [7:0] ch;
		logic       run_end;
		logic       text_end;
	} decoded_t;

	// Predicts the decoded bytes for every accepted text item and checks what comes out
	// against them in order.
	class decoder_scoreboard;
		scan_mode_t  mode;
		logic [7:0]  held [HOLD_DEPTH];
		int unsigned held_cnt;
		logic [31:0] code_val;
		logic        hex_form;
		string       ent_text [NUM_ENT];
		logic [7:0]  ent_subst [NUM_ENT];
		logic [7:0]  step_bytes [$];
		decoded_t    expected_bytes [$];
		int unsigned mismatches;

		function new();
			ent_text   = '{"lt;", "gt;", "amp;", "apos;", "quot;"};
			ent_subst  = '{8'h3c, 8'h3e, CH_AMP, 8'h27, 8'h22};
			mismatches = 0;
			clear_entity();
		endfunction

		function void clear_entity();
			mode     = SCAN_IDLE;
			held_cnt = 0;
			code_val = '0;
			hex_form = 1'b0;
		endfunction

		// An open entity leaves as '&' followed by its held text, unchanged.
		function void flush_entity();
			if (mode != SCAN_IDLE) begin
				step_bytes.insert(step_bytes.size(), CH_AMP);
				for (int i = 0; i < held_cnt; i++)
					step_bytes.insert(step_bytes.size(), held[i]);
			end
			clear_entity();
		endfunction

		function void idle_byte(logic [7:0] c);
			if (c == CH_AMP) begin
				clear_entity();
				mode = SCAN_AMP;
			end else begin
				step_bytes.insert(step_bytes.size(), c);
			end
		endfunction

		// The byte that broke the entity is then taken as a fresh byte.
		function void fail_entity(logic [7:0] c);
			flush_entity();
			idle_byte(c);
		endfunction

		function bit hold_byte(logic [7:0] c);
			if (held_cnt >= HOLD_DEPTH)
				return 1'b0;
			held[held_cnt] = c;
			held_cnt++;
			return 1'b1;
		endfunction

		function int digit_of(logic [7:0] c);
			if (c >= "0" && c <= "9")
				return int'(c) - int'("0");
			if (c >= "a" && c <= "f")
				return int'(c) - int'("a") + 10;
			if (c >= "A" && c <= "F")
				return int'(c) - int'("A") + 10;
			return -1;
		endfunction

		function void name_step(logic [7:0] c);
			int unsigned n;
			bit          is_prefix;
			bit          same;
			n         = held_cnt;
			is_prefix = 1'b0;
			for (int k = 0; k < NUM_ENT; k++) begin
				if (n + 1 > ent_text[k].len())
					continue;
				same = (ent_text[k][n] == c);
				for (int i = 0; i < n; i++)
					if (held[i] != ent_text[k][i])
						same = 1'b0;
				if (!same)
					continue;
				if (n + 1 == ent_text[k].len()) begin
					step_bytes.insert(step_bytes.size(), ent_subst[k]);
					clear_entity();
					return;
				end
				is_prefix = 1'b1;
			end
			if (is_prefix && hold_byte(c))
				mode = SCAN_NAME;
			else
				fail_entity(c);
		endfunction

		function void num_step(logic [7:0] c);
			int v;
			if (mode == SCAN_NUM_START && c == CH_X) begin
				if (!hold_byte(c)) begin
					fail_entity(c);
					return;
				end
				hex_form = 1'b1;
				mode     = SCAN_NUM_DIG;
				return;
			end
			if (c == CH_SEMI) begin
				if (code_val == 0) begin
					fail_entity(c);
					return;
				end
				// Bytes of the code point up to its highest nonzero byte, least significant first.
				while (code_val != 0) begin
					step_bytes.insert(step_bytes.size(), code_val[7:0]);
					code_val = code_val >> 8;
				end
				clear_entity();
				return;
			end
			v = digit_of(c);
			if (v < 0 || !hold_byte(c)) begin
				fail_entity(c);
				return;
			end
			code_val = code_val * (hex_form ? 32'd16 : 32'd10) + 32'(v);
			mode     = SCAN_NUM_DIG;
		endfunction

		function void note_input(logic [7:0] c, logic fin);
			decoded_t d;
			step_bytes.delete();
			case (mode)
				SCAN_AMP: begin
					if (c == CH_HASH) begin
						if (hold_byte(c))
							mode = SCAN_NUM_START;
						else
							fail_entity(c);
					end else begin
						name_step(c);
					end
				end
				SCAN_NAME: name_step(c);
				SCAN_NUM_START, SCAN_NUM_DIG: num_step(c);
				default: begin
					mode = SCAN_IDLE;
					idle_byte(c);
				end
			endcase
			if (fin)
				flush_entity();
			foreach (step_bytes[i]) begin
				d.ch       = step_bytes[i];
				d.run_end  = (i == step_bytes.size() - 1);
				d.text_end = d.run_end && fin;
				expected_bytes.insert(expected_bytes.size(), d);
			end
		endfunction

		function void check_result(logic [7:0] ch, logic run_end, logic text_end);
			decoded_t want;
			if (expected_bytes.size() == 0) begin
				$error("out_byte: expected nothing, got %h", ch);
				mismatches++;
				return;
			end
			want = expected_bytes.pop_front();
			if (ch !== want.ch) begin
				$error("out_byte: expected %h, got %h", want.ch, ch);
				mismatches++;
			end
			if (run_end !== want.run_end) begin
				$error("run_end: expected %b, got %b", want.run_end, run_end);
				mismatches++;
			end
			if (text_end !== want.text_end) begin
				$error("text_end: expected %b, got %b", want.text_end, text_end);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	xeu_in_if  text_in();
	xeu_out_if text_out();

	xml_entity_unescaper dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.text_in (text_in),
		.text_out(text_out)
	);

	decoder_scoreboard sb;

	// Bytes of the token being built, and the pacing knobs shared by both sides.
	logic [7:0]  token_q [$];
	int unsigned items_sent;
	int unsigned send_gap_odds;
	int unsigned recv_stall_odds;
	bit          quiet;
	int unsigned cycle_count;

	always #CLK_HALF clk = ~clk;

	// The run is cut short if it hangs; the limit is many times the slowest correct run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Both channels are watched at the clock edge: an accepted text item feeds the
	// prediction, an accepted decoded byte is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (text_in.valid === 1'b1 && text_in.ready === 1'b1)
				sb.note_input(text_in.in_byte, text_in.in_final);
			if (text_out.valid === 1'b1 && text_out.ready === 1'b1)
				sb.check_result(text_out.out_byte, text_out.run_end, text_out.text_end);
		end
	end

	// The result side stalls in bursts of random length, at a rate that the stimulus
	// changes from time to time; a rate of zero gives a stretch with no stalls at all.
	initial begin : result_pacing
		int unsigned stall_left;
		stall_left     = 0;
		text_out.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left != 0) begin
				text_out.ready <= 1'b0;
				stall_left--;
			end else if (!quiet && recv_stall_odds != 0
					&& $urandom_range(0, recv_stall_odds) == 0) begin
				text_out.ready <= 1'b0;
				stall_left = $urandom_range(0, 2);
			end else begin
				text_out.ready <= 1'b1;
			end
		end
	end

	// Offers one text item and waits until the block takes it. A random gap may come
	// first, so gaps land in every phase of an entity.
	task automatic send_item(input logic [7:0] ch, input logic fin);
		if (!quiet && send_gap_odds != 0 && $urandom_range(0, send_gap_odds) == 0) begin
			text_in.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		text_in.valid    <= 1'b1;
		text_in.in_byte  <= ch;
		text_in.in_final <= fin;
		do @(posedge clk); while (text_in.ready !== 1'b1);
		items_sent++;
	endtask

	// Sends the built token. The last item closes the text when asked; with noise on, an
	// end of text may also fall in the middle of the token, cutting an entity short.
	task automatic send_token(input bit ends_text, input bit noisy);
		logic fin;
		foreach (token_q[i]) begin
			fin = (ends_text && i == token_q.size() - 1)
				|| (noisy && $urandom_range(0, 39) == 0);
			send_item(token_q[i], fin);
		end
		token_q.delete();
	endtask

	task automatic add_text(input string s);
		foreach (s[i])
			token_q.insert(token_q.size(), s[i]);
	endtask

	// Opening of a numeric reference, in hex or decimal form.
	task automatic add_num_open(input bit hex);
		if (hex)
			add_text("&#x");
		else
			add_text("&#");
	endtask

	// Digits for a numeric reference. Decimal digits now and then include hex letters,
	// which the decoder takes at base ten.
	task automatic add_digits(input int unsigned n, input bit hex);
		string hex_set;
		hex_set = "0123456789abcdefABCDEF";
		repeat (n) begin
			if (hex || $urandom_range(0, 7) == 0)
				token_q.insert(token_q.size(),
					hex_set[$urandom_range(0, hex_set.len() - 1)]);
			else
				token_q.insert(token_q.size(), 8'h30 + 8'($urandom_range(0, 9)));
		end
	endtask

	// Builds one token of random content. Close to half are well-formed entities, so that the
	// decoder gets past its opening states; the rest are plain bytes and broken entities.
	task automatic build_random_token();
		int unsigned pick;
		int unsigned k;
		string       name;
		bit          hex;
		pick = $urandom_range(0, 99);
		k    = $urandom_range(0, NUM_ENT - 1);
		hex  = 1'($urandom_range(0, 1));
		case (sb.ent_text[k])
			default: name = sb.ent_text[k];
		endcase
		if (pick < 20) begin
			token_q.insert(token_q.size(), 8'($urandom_range(0, 255)));
		end else if (pick < 45) begin
			add_text({"&", name});
		end else if (pick < 55) begin
			// A named entity broken after a proper prefix by an arbitrary byte.
			add_text({"&", name.substr(0, $urandom_range(0, name.len() - 2))});
			token_q.insert(token_q.size(), 8'($urandom_range(0, 255)));
		end else if (pick < 75) begin
			add_num_open(hex);
			if ($urandom_range(0, 4) == 0)
				add_digits($urandom_range(9, 14), hex);
			else
				add_digits($urandom_range(1, hex ? 8 : 10), hex);
			token_q.insert(token_q.size(), CH_SEMI);
		end else if (pick < 82) begin
			// A numeric reference whose value is zero, or that has no digits at all.
			add_num_open(hex);
			repeat ($urandom_range(0, 3)) token_q.insert(token_q.size(), "0");
			token_q.insert(token_q.size(), CH_SEMI);
		end else if (pick < 90) begin
			add_num_open(hex);
			add_digits($urandom_range(0, 4), hex);
			token_q.insert(token_q.size(), 8'($urandom_range(0, 255)));
		end else if (pick < 95) begin
			// Enough decimal digits to fill the hold buffer or to overrun it.
			add_text("&#");
			add_digits($urandom_range(HOLD_DEPTH - 1, HOLD_DEPTH + 2), 1'b0);
			token_q.insert(token_q.size(), CH_SEMI);
		end else if (pick < 98) begin
			add_text("&#X41;");
		end else begin
			add_text("&&lt;");
		end
	endtask

	// Holds the input back until every predicted byte has come out.
	task automatic pause_until_drained();
		text_in.valid <= 1'b0;
		do @(posedge clk); while (sb.expected_bytes.size() != 0);
	endtask

	initial begin : stimulus
		bit pressure_done;
		sb               = new();
		arst_n           = 1'b0;
		text_in.valid    = 1'b0;
		text_in.in_byte  = 8'h00;
		text_in.in_final = 1'b0;
		items_sent       = 0;
		cycle_count      = 0;
		send_gap_odds    = 3;
		recv_stall_odds  = 3;
		quiet            = 1'b0;
		pressure_done    = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: a named entity, a hex reference, a numeric reference with no
		// value, a name that breaks, the extreme byte values, and an entity left open
		// at the end of the text.
		add_text("&lt;");
		send_token(1'b0, 1'b0);
		add_text("&#x41;");
		send_token(1'b0, 1'b0);
		add_text("&#;");
		send_token(1'b0, 1'b0);
		add_text("&qz");
		send_token(1'b0, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'hff, 1'b0);
		add_text("&ap");
		send_token(1'b1, 1'b0);
		pause_until_drained();

		// Random part: the idling rates on both sides change now and then, a rate of
		// zero giving a stretch with no idling; the final stretch has none at all.
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if (items_sent >= RANDOM_ITEMS - QUIET_ITEMS) begin
				quiet = 1'b1;
			end else if ($urandom_range(0, 24) == 0) begin
				send_gap_odds   = 2 * $urandom_range(0, 3);
				recv_stall_odds = 2 * $urandom_range(0, 3);
			end
			if (!pressure_done && items_sent >= RANDOM_ITEMS / 2) begin
				pause_until_drained();
				pressure_done = 1'b1;
			end
			build_random_token();
			send_token($urandom_range(0, 7) == 0, 1'b1);
		end
		// Close the text so that nothing is left held in the decoder.
		add_text(".");
		send_token(1'b1, 1'b0);

		text_in.valid <= 1'b0;
		do @(posedge clk); while (sb.expected_bytes.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_bytes.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
